/* hdl/ajpd_pkg.sv */
// ============================================================================
// Jump peak detector package
// Shared types, constants and the filter coefficient table.
// ============================================================================
package ajpd_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int AXIS_W       = 12;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 16;
    localparam int INTERVAL_W   = 16;
    localparam int FIR_TAPS_DEF = 7;
    localparam int COEF_W       = 14;
    localparam int ACC_W        = 32;
    localparam int SUM_W        = 24;
    localparam int ROUND_SHIFT  = 15;
    localparam int ROUND_HALF   = 16384;
    localparam int NUM_SQUARES  = 3;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [SAMPLE_BITS-1:0] MAG_MAX        = '1;
    localparam logic [COUNT_W-1:0]     COUNT_MAX      = '1;
    localparam logic [SUM_W-1:0]       SQRT_START_BIT = SUM_W'(1) << (SUM_W - 2);

    localparam logic [COEF_W-1:0] TAP_EDGE  = COEF_W'(1262);
    localparam logic [COEF_W-1:0] TAP_OUTER = COEF_W'(3588);
    localparam logic [COEF_W-1:0] TAP_INNER = COEF_W'(6619);
    localparam logic [COEF_W-1:0] TAP_MID   = COEF_W'(8192);

    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = INTERVAL_W'(200);

    typedef enum logic [1:0] {
        REG_DETECT_ENABLE   = 2'd0,
        REG_PEAK_THRESHOLD  = 2'd1,
        REG_RESET_LEVEL     = 2'd2,
        REG_MIN_INTERVAL_MS = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_FIR,
        ST_DECIDE
    } seq_state_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic        [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic                   jump;
        logic [SAMPLE_BITS-1:0] smoothed_mag;
        logic [COUNT_W-1:0]     jump_count;
    } result_t;

    // Command word for the shared multiply-accumulate unit.
    typedef struct packed {
        logic                   en;
        logic                   clear;
        logic [COEF_W-1:0]      a;
        logic [SAMPLE_BITS-1:0] b;
    } mac_cmd_t;

    // Symmetric taps: the weight depends on the distance from the nearer end.
    function automatic logic [COEF_W-1:0] tap_coeff(input int k, input int taps);
        int d;
        d = k;
        if (taps - 1 - k < d) d = taps - 1 - k;
        if (d > 3) d = 3;
        if (d < 0) d = 0;
        case (d)
            0:       return TAP_EDGE;
            1:       return TAP_OUTER;
            2:       return TAP_INNER;
            default: return TAP_MID;
        endcase
    endfunction

endpackage

/* hdl/ajpd_mac.sv */
// ============================================================================
// Shared multiply-accumulate unit
// One unsigned multiplier feeding a clearable accumulator; used for the axis
// squares and for every filter tap.
// ============================================================================
module ajpd_mac
    import ajpd_pkg::*;
(
    input  logic             clk,
    input  mac_cmd_t         cmd,
    output logic [ACC_W-1:0] acc
);

    logic [COEF_W+SAMPLE_BITS-1:0] prod;
    logic [ACC_W-1:0]              acc_reg;
    logic [ACC_W-1:0]              acc_next;

    assign prod = cmd.a * cmd.b;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.en)
        begin
            if (cmd.clear)
                acc_next = ACC_W'(prod);
            else
                acc_next = acc_reg + ACC_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* hdl/ajpd_sqrt.sv */
// ============================================================================
// Iterative square root
// Digit-by-digit floor square root, one result bit per clock cycle.
// ============================================================================
module ajpd_sqrt
    import ajpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SUM_W-1:0]       radicand,
    output logic                   done,
    output logic [SAMPLE_BITS-1:0] root
);

    logic             busy_reg;
    logic             done_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] root_reg;
    logic [SUM_W-1:0] bit_reg;
    logic [SUM_W:0]   trial;
    logic             fits;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = ({1'b0, rem_reg} >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= SQRT_START_BIT;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg  <= rem_reg - trial[SUM_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // The radicand stays below 2^24, so the root always fits in 12 bits.
    assign done = done_reg;
    assign root = root_reg[SAMPLE_BITS-1:0];

endmodule

/* hdl/accel_jump_peak_detector_core.sv */
// ============================================================================
// Accelerometer jump peak detector
// Magnitude by iterative square root, symmetric low-pass FIR on a shared
// multiply-accumulate unit, and peak detection with hysteresis and debounce.
// ============================================================================
// Each accepted item runs in order through three axis squares on the shared multiplier,
// a square root start and wait, one multiply-accumulate per filter tap and a decision.
// No new item is accepted before the sequencer is idle again, the pace being set by the
// shared multiplier and the one-bit-per-cycle square root; a stalled result holds the block
// until it is taken. Disabled items are accepted and dropped while idle. Reset is
// asynchronous and clears filter history, peak state, jump count and registers to defaults.
module accel_jump_peak_detector_core
    import ajpd_pkg::*;
#(
    parameter int FIR_TAPS = FIR_TAPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  sample_t            sample,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W     = $clog2(FIR_TAPS);
    localparam int DLY_DEPTH = FIR_TAPS - 1;
    localparam int DLY_IDX_W = $clog2(DLY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_TAP    = IDX_W'(FIR_TAPS - 1);
    localparam logic [IDX_W-1:0] LAST_SQUARE = IDX_W'(NUM_SQUARES - 1);

    // Configuration registers
    logic                   enable_reg;
    logic [SAMPLE_BITS-1:0] threshold_reg;
    logic [SAMPLE_BITS-1:0] reset_level_reg;
    logic [INTERVAL_W-1:0]  min_interval_reg;
    reg_index_t             reg_index;
    logic                   cfg_write;

    // Sequencer and datapath
    seq_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    sample_t                sample_reg;
    mac_cmd_t               mac_cmd;
    logic [ACC_W-1:0]       acc;
    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [SAMPLE_BITS-1:0] magnitude;
    logic [AXIS_W-1:0]      axis_val;
    logic [AXIS_W-1:0]      axis_abs;
    logic [IDX_W-1:0]       dly_sel;
    logic [SAMPLE_BITS-1:0] dly_rd;
    logic [SAMPLE_BITS-1:0] fir_dly_reg [DLY_DEPTH];

    // Peak state
    logic [SAMPLE_BITS-1:0] prev_mag_reg, prev_mag_next;
    logic                   rising_seen_reg, rising_seen_next;
    logic                   await_drop_reg, await_drop_next;
    logic [TIME_W-1:0]      last_jump_reg, last_jump_next;
    logic [COUNT_W-1:0]     jump_total_reg, jump_total_next;
    logic                   jump;

    // Decision terms
    logic [ACC_W-1:0]       rounded;
    logic [SAMPLE_BITS-1:0] filt;
    logic [TIME_W-1:0]      elapsed;
    logic                   interval_ok;
    logic                   take;
    logic                   accept;

    logic                   result_valid_reg;
    result_t                result_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            threshold_reg    <= '0;
            reset_level_reg  <= '0;
            min_interval_reg <= MIN_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_DETECT_ENABLE:   enable_reg       <= pwdata[0];
                REG_PEAK_THRESHOLD:  threshold_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_RESET_LEVEL:     reset_level_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_MIN_INTERVAL_MS: min_interval_reg <= pwdata[INTERVAL_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DETECT_ENABLE:   prdata = PDATA_W'(enable_reg);
            REG_PEAK_THRESHOLD:  prdata = PDATA_W'(threshold_reg);
            REG_RESET_LEVEL:     prdata = PDATA_W'(reset_level_reg);
            REG_MIN_INTERVAL_MS: prdata = PDATA_W'(min_interval_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    ajpd_mac u_mac (
        .clk (clk),
        .cmd (mac_cmd),
        .acc (acc)
    );

    ajpd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc[SUM_W-1:0]),
        .done     (sqrt_done),
        .root     (magnitude)
    );

    // ------------------------------------------------------------------
    // Operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        case (idx_reg)
            IDX_W'(0): axis_val = sample_reg.accel_x;
            IDX_W'(1): axis_val = sample_reg.accel_y;
            default:   axis_val = sample_reg.accel_z;
        endcase
    end

    // The most negative count maps to 2048, which still fits unsigned.
    assign axis_abs = axis_val[AXIS_W-1] ? (~axis_val + AXIS_W'(1)) : axis_val;
    assign dly_sel  = idx_reg - IDX_W'(1);
    assign dly_rd   = fir_dly_reg[dly_sel[DLY_IDX_W-1:0]];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign take         = (state_reg == ST_DECIDE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        sqrt_start    = 1'b0;
        mac_cmd.en    = 1'b0;
        mac_cmd.clear = 1'b0;
        mac_cmd.a     = COEF_W'(axis_abs);
        mac_cmd.b     = SAMPLE_BITS'(axis_abs);
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept && enable_reg)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                mac_cmd.en    = 1'b1;
                mac_cmd.clear = (idx_reg == '0);
                if (idx_reg == LAST_SQUARE)
                begin
                    idx_next   = '0;
                    state_next = ST_ROOT_START;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_ROOT_START:
            begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                    state_next = ST_FIR;
            end
            ST_FIR:
            begin
                mac_cmd.en    = 1'b1;
                mac_cmd.clear = (idx_reg == '0);
                mac_cmd.a     = tap_coeff(int'(idx_reg), FIR_TAPS);
                mac_cmd.b     = (idx_reg == '0) ? magnitude : dly_rd;
                if (idx_reg == LAST_TAP)
                begin
                    idx_next   = '0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= sample;
    end

    // ------------------------------------------------------------------
    // Filter output and peak decision
    // ------------------------------------------------------------------
    assign rounded     = (acc + ACC_W'(ROUND_HALF)) >> ROUND_SHIFT;
    assign filt        = (rounded > ACC_W'(MAG_MAX)) ? MAG_MAX : rounded[SAMPLE_BITS-1:0];
    assign elapsed     = sample_reg.now_ms - last_jump_reg;
    assign interval_ok = (elapsed >= TIME_W'(min_interval_reg));

    always_comb
    begin
        prev_mag_next    = prev_mag_reg;
        rising_seen_next = rising_seen_reg;
        await_drop_next  = await_drop_reg;
        last_jump_next   = last_jump_reg;
        jump_total_next  = jump_total_reg;
        jump             = 1'b0;
        if (take)
        begin
            // After a jump, only a drop below the reset level re-arms detection.
            if (await_drop_reg)
            begin
                if (filt < reset_level_reg)
                    await_drop_next = 1'b0;
            end
            else if (prev_mag_reg < filt)
            begin
                rising_seen_next = 1'b1;
            end
            else if (rising_seen_reg && (prev_mag_reg > filt))
            begin
                if ((prev_mag_reg > threshold_reg) && interval_ok)
                begin
                    jump            = 1'b1;
                    last_jump_next  = sample_reg.now_ms;
                    await_drop_next = 1'b1;
                    if (jump_total_reg != COUNT_MAX)
                        jump_total_next = jump_total_reg + COUNT_W'(1);
                end
                rising_seen_next = 1'b0;
            end
            prev_mag_next = filt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mag_reg    <= '0;
            rising_seen_reg <= 1'b0;
            await_drop_reg  <= 1'b0;
            last_jump_reg   <= '0;
            jump_total_reg  <= '0;
            for (int i = 0; i < DLY_DEPTH; i++)
                fir_dly_reg[i] <= '0;
        end
        else
        begin
            prev_mag_reg    <= prev_mag_next;
            rising_seen_reg <= rising_seen_next;
            await_drop_reg  <= await_drop_next;
            last_jump_reg   <= last_jump_next;
            jump_total_reg  <= jump_total_next;
            if (take)
            begin
                for (int i = DLY_DEPTH - 1; i > 0; i--)
                    fir_dly_reg[i] <= fir_dly_reg[i-1];
                fir_dly_reg[0] <= magnitude;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (take)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg.jump         <= jump;
            result_reg.smoothed_mag <= filt;
            result_reg.jump_count   <= jump_total_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result appeared without a decision cycle");

    a_jump_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.jump |-> result.jump_count != '0)
        else $error("jump reported with a zero count");

    a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == ST_ROOT_WAIT)
        else $error("square root finished outside its wait state");

    a_arm_clears_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(await_drop_reg) |-> !rising_seen_reg)
        else $error("rise flag left set after a counted jump");

endmodule

/* test/ajpd_result_checker.sv */
// ============================================================================
// Jump peak detector result checker
// Watches the sample, result and register ports, predicts every result from
// the accepted samples and compares it field by field in arrival order.
// ============================================================================
module ajpd_result_checker
    import ajpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic               sample_stall,
    input  sample_t            sample,
    input  logic               result_valid,
    input  logic               result_stall,
    input  result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 pending,
    output int                 checked_count,
    output int                 jumps_seen,
    output int                 ignored_count
);

    localparam int W_EDGE     = 1262;
    localparam int W_OUTER    = 3588;
    localparam int W_INNER    = 6619;
    localparam int W_MID      = 8192;
    localparam int HIST_DEPTH = 6;
    localparam int MAG_LIMIT  = 4095;

    // Register copies.
    logic                   enable_q;
    logic [SAMPLE_BITS-1:0] threshold_q;
    logic [SAMPLE_BITS-1:0] rearm_level_q;
    logic [INTERVAL_W-1:0]  debounce_ms_q;

    // Detector state.
    int                 mag_hist [HIST_DEPTH];
    int                 last_filt;
    logic               rising_q;
    logic               await_drop_q;
    logic [TIME_W-1:0]  last_jump_ms_q;
    logic [COUNT_W-1:0] total_q;

    result_t expected_q[$];
    int      errors;
    int      checks;
    int      jumps;
    int      ignored;

    function automatic int floor_root(input int energy);
        int root;
        int probe;
        root = 0;
        // The largest magnitude is about 3547, so twelve bits suffice.
        for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
            probe = root | (1 << b);
            if (probe * probe <= energy)
                root = probe;
        end
        return root;
    endfunction

    task automatic advance_detector(input sample_t s);
        int                ax;
        int                ay;
        int                az;
        int                mag;
        int                acc;
        int                filt;
        logic [TIME_W-1:0] elapsed;
        result_t           r;
        ax  = $signed(s.accel_x);
        ay  = $signed(s.accel_y);
        az  = $signed(s.accel_z);
        mag = floor_root(ax * ax + ay * ay + az * az);

        acc = W_EDGE  * (mag + mag_hist[5])
            + W_OUTER * (mag_hist[0] + mag_hist[4])
            + W_INNER * (mag_hist[1] + mag_hist[3])
            + W_MID   * mag_hist[2];
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            mag_hist[k] = mag_hist[k-1];
        mag_hist[0] = mag;
        filt = (acc + 16384) >> 15;
        if (filt > MAG_LIMIT)
            filt = MAG_LIMIT;

        r.jump = 1'b0;
        if (await_drop_q) begin
            if (filt < int'(rearm_level_q))
                await_drop_q = 1'b0;
        end
        else if (last_filt < filt) begin
            rising_q = 1'b1;
        end
        else if (rising_q && last_filt > filt) begin
            // The elapsed time wraps, so a timestamp that goes back reads as long.
            elapsed = s.now_ms - last_jump_ms_q;
            if (last_filt > int'(threshold_q) && elapsed >= TIME_W'(debounce_ms_q)) begin
                r.jump = 1'b1;
                if (total_q != COUNT_MAX)
                    total_q = total_q + 1'b1;
                last_jump_ms_q = s.now_ms;
                await_drop_q   = 1'b1;
            end
            rising_q = 1'b0;
        end
        last_filt = filt;

        r.smoothed_mag = SAMPLE_BITS'(filt);
        r.jump_count   = total_q;
        expected_q.push_back(r);
    endtask

    task automatic compare_result(input result_t got);
        result_t want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result jump=%0d smoothed=%0d count=%0d", $time,
                     got.jump, got.smoothed_mag, got.jump_count);
            return;
        end
        want = expected_q.pop_front();
        checks++;
        if (want.jump)
            jumps++;
        if (got.jump !== want.jump) begin
            errors++;
            $display("%0t: jump mismatch, expected %0d, actual %0d", $time,
                     want.jump, got.jump);
        end
        if (got.smoothed_mag !== want.smoothed_mag) begin
            errors++;
            $display("%0t: smoothed_mag mismatch, expected %0d, actual %0d", $time,
                     want.smoothed_mag, got.smoothed_mag);
        end
        if (got.jump_count !== want.jump_count) begin
            errors++;
            $display("%0t: jump_count mismatch, expected %0d, actual %0d", $time,
                     want.jump_count, got.jump_count);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            enable_q       = 1'b0;
            threshold_q    = '0;
            rearm_level_q  = '0;
            debounce_ms_q  = MIN_INTERVAL_RST;
            foreach (mag_hist[i])
                mag_hist[i] = 0;
            last_filt      = 0;
            rising_q       = 1'b0;
            await_drop_q   = 1'b0;
            last_jump_ms_q = '0;
            total_q        = '0;
            expected_q.delete();
            errors         = 0;
            checks         = 0;
            jumps          = 0;
            ignored        = 0;
            fail_count    <= 0;
            pending       <= 0;
            checked_count <= 0;
            jumps_seen    <= 0;
            ignored_count <= 0;
        end
        else begin
            // A result can never belong to the item accepted at the same edge.
            if (result_valid && !result_stall)
                compare_result(result);
            if (sample_valid && !sample_stall) begin
                if (enable_q)
                    advance_detector(sample);
                else
                    ignored++;
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (reg_index_t'(paddr[PADDR_W-1:2]))
                    REG_DETECT_ENABLE:   enable_q      = pwdata[0];
                    REG_PEAK_THRESHOLD:  threshold_q   = pwdata[SAMPLE_BITS-1:0];
                    REG_RESET_LEVEL:     rearm_level_q = pwdata[SAMPLE_BITS-1:0];
                    REG_MIN_INTERVAL_MS: debounce_ms_q = pwdata[INTERVAL_W-1:0];
                    default: ;
                endcase
            end
            fail_count    <= errors;
            pending       <= expected_q.size();
            checked_count <= checks;
            jumps_seen    <= jumps;
            ignored_count <= ignored;
        end
    end

endmodule

/* test/tb_accel_jump_peak_detector_core.sv */
// ============================================================================
// Jump peak detector testbench
// Drives directed and shaped random accelerometer samples under several
// register settings, with random idling on both sides, and reports a verdict
// from the failure count of the result checker.
// ============================================================================
module tb_accel_jump_peak_detector_core
    import ajpd_pkg::*;
();

    localparam int DRAIN_CYCLES = 2 * (18 + FIR_TAPS_DEF);
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 400;

    logic               clk;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_stall;
    sample_t            sample;
    logic               result_valid;
    logic               result_stall;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int checked_count;
    int jumps_seen;
    int ignored_count;

    logic [TIME_W-1:0] stamp_ms;
    bit                stamp_glitch;
    bit                tx_quiet;
    bit                rx_quiet;
    int                hold_cycles;
    int                sent_total;
    int                setting_count;

    accel_jump_peak_detector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    ajpd_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .jumps_seen    (jumps_seen),
        .ignored_count (ignored_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("accel_jump_peak_detector_core verification failed");
        $finish;
    end

    function automatic logic signed [AXIS_W-1:0] clamp_axis(input int v);
        if (v > 2047)
            return AXIS_W'(2047);
        if (v < -2048)
            return AXIS_W'(-2048);
        return AXIS_W'(v);
    endfunction

    task automatic offer_axes(input int x, input int y, input int z);
        int      gap;
        sample_t s;
        gap       = tx_quiet ? 0 : $urandom_range(0, 10);
        s.accel_x = clamp_axis(x);
        s.accel_y = clamp_axis(y);
        s.accel_z = clamp_axis(z);
        s.now_ms  = stamp_ms;
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sent_total++;
        // Roughly 50 Hz, with an occasional jump to any timestamp at all.
        stamp_ms += $urandom_range(15, 25);
        if (stamp_glitch && $urandom_range(0, 39) == 0)
            stamp_ms = $urandom;
    endtask

    // One axis carries the level with a random sign; the others carry noise.
    task automatic offer_level(input int level, input int noise);
        int lane;
        int a [3];
        lane = $urandom_range(0, 2);
        foreach (a[i])
            a[i] = int'($urandom_range(0, 2 * noise)) - noise;
        a[lane] = $urandom_range(0, 1) ? level : -level;
        offer_axes(a[0], a[1], a[2]);
    endtask

    task automatic wait_for_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_index_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input int unsigned en, input int unsigned thr,
                            input int unsigned lvl, input int unsigned debounce);
        wait_for_results();
        apb_write(REG_DETECT_ENABLE, en);
        apb_write(REG_PEAK_THRESHOLD, thr);
        apb_write(REG_RESET_LEVEL, lvl);
        apb_write(REG_MIN_INTERVAL_MS, debounce);
        setting_count++;
    endtask

    // Mostly jump-shaped sequences (rest near 1 g, a peak, a landing dip),
    // with bursts of raw noise in between.
    task automatic run_stream(input int items);
        int stop;
        int reps;
        stop = sent_total + items;
        while (sent_total < stop) begin
            if ($urandom_range(0, 9) < 2) begin
                reps = $urandom_range(1, 5);
                repeat (reps)
                    offer_axes(int'($urandom_range(0, 4095)) - 2048,
                               int'($urandom_range(0, 4095)) - 2048,
                               int'($urandom_range(0, 4095)) - 2048);
            end
            else begin
                reps = $urandom_range(2, 8);
                repeat (reps) offer_level($urandom_range(980, 1070), 40);
                reps = $urandom_range(2, 4);
                repeat (reps) offer_level($urandom_range(1200, 3500), 60);
                reps = $urandom_range(1, 3);
                repeat (reps) offer_level($urandom_range(150, 800), 60);
            end
            if ($urandom_range(0, 59) == 0)
                wait_for_results();
        end
    endtask

    initial begin
        int n;
        result_stall <= 1'b0;
        forever begin
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
            end
            else begin
                n = rx_quiet ? 0 : $urandom_range(0, 10);
            end
            if (n > 0) begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    initial begin
        rst_n         <= 1'b0;
        sample_valid  <= 1'b0;
        sample        <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        stamp_ms       = '0;
        stamp_glitch   = 1'b0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        hold_cycles    = 0;
        sent_total     = 0;
        setting_count  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the block is disabled and must give no result.
        repeat (4) offer_level(1500, 100);

        // Directed: axis extremes, peaks before the debounce time has passed,
        // a flat signal, a late jump and a jump with a timestamp that goes back.
        set_regs(1, 900, 700, 200);
        stamp_ms = '0;
        offer_axes(0, 0, 0);
        offer_axes(-2048, -2048, -2048);
        offer_axes(2047, 2047, 2047);
        offer_axes(-2048, 2047, -1);
        offer_axes(0, 0, 0);
        offer_axes(0, 0, 0);
        repeat (4) offer_axes(0, 0, 1024);
        stamp_ms = 5000;
        repeat (3) offer_axes(3000, 0, 0);
        repeat (5) offer_axes(0, 0, 0);
        stamp_ms = 100;
        repeat (3) offer_axes(0, 2000, 2000);
        repeat (5) offer_axes(0, 0, 0);

        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        set_regs(1, 1500, 1100, 200);
        run_stream(60);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        run_stream(100);

        set_regs(1, 0, 4095, 0);
        run_stream(100);

        set_regs(1, 4095, 0, 65535);
        run_stream(60);

        set_regs(0, 1000, 900, 100);
        run_stream(20);

        // The receiver holds off for a long stretch so the block backs up.
        set_regs(1, $urandom_range(800, 2500), $urandom_range(900, 1400),
                 $urandom_range(0, 300));
        hold_cycles = LONG_HOLD;
        run_stream(150);

        // Timestamps wrap past 2^32 and jump around at random.
        set_regs(1, 1200, 1000, 65535);
        stamp_glitch = 1'b1;
        stamp_ms     = 32'hFFFF_FF00;
        run_stream(100);

        set_regs(1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 65535));
        run_stream(150);

        wait_for_results();
        $display("Run drove %0d samples (%0d dropped while disabled) over %0d register settings,",
                 sent_total, ignored_count, setting_count);
        $display("checking %0d results of which %0d carried a counted jump.",
                 checked_count, jumps_seen);
        if (fail_count == 0)
            $display("accel_jump_peak_detector_core verification clean");
        else
            $display("accel_jump_peak_detector_core verification failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/ajpd_pkg.sv
hdl/ajpd_mac.sv
hdl/ajpd_sqrt.sv
hdl/accel_jump_peak_detector_core.sv
test/ajpd_result_checker.sv
test/tb_accel_jump_peak_detector_core.sv
